[rtl/wildcard_name_match_assert.svh]
// ----------------------------------------------------------------------------
// wildcard name match assertion macros
// concurrent checks on the block clock, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef WILDCARD_NAME_MATCH_ASSERT_SVH
`define WILDCARD_NAME_MATCH_ASSERT_SVH

`ifndef SYNTHESIS

// check that holds whenever the antecedent holds, same cycle
`define WNM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wildcard_name_match: assertion failed");

// check on the cycle after the antecedent
`define WNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wildcard_name_match: assertion failed");

`else

`define WNM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define WNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/wnm_pkg.sv]
// ----------------------------------------------------------------------------
// wnm_pkg
// request and result types, request codes and character folding
// ----------------------------------------------------------------------------
package wnm_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
  } wnm_in_t;

  typedef struct packed {
    logic matched;
    logic mask_too_long;
  } wnm_out_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic       restart;
    logic       load;
    logic       step;
    logic [7:0] chr;
  } wnm_ctrl_t;

  // handed from a cell to its right neighbor
  typedef struct packed {
    logic act;
    logic star;
    logic adv;
  } wnm_link_t;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_NAME   = 2'd2;
  localparam logic [1:0] REQ_END    = 2'd3;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUES   = 8'h3F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // lower-case ascii letters, backslash reads as slash
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] f;
    f = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      f = c | CASE_BIT;
    end
    if (c == CH_BSLASH) begin
      f = CH_SLASH;
    end
    return f;
  endfunction

endpackage

[rtl/wnm_cell.sv]
// ----------------------------------------------------------------------------
// wnm_cell
// one mask position: stored mask character and its active bit
// ----------------------------------------------------------------------------
module wnm_cell
  import wnm_pkg::*;
#(
  parameter int LEN_W = 7,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wnm_ctrl_t        ctrl,
  input  logic [LEN_W-1:0] len,
  input  wnm_link_t        left,
  output wnm_link_t        right,
  output logic             eff
);

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [7:0] chr_r;
  logic       is_star_r;
  logic       is_ques_r;
  logic       act_r;
  logic       act_nxt;
  logic       in_use;
  logic       hit;

  assign in_use = MY_IDX < len;

  // closed active: a star on the left also opens this position
  assign eff = act_r | (left.star & left.act);

  assign hit = in_use & ~is_star_r & (is_ques_r | (chr_r == ctrl.chr));

  assign right.act  = act_r;
  assign right.star = in_use & is_star_r;
  assign right.adv  = eff & hit;

  always_comb begin
    act_nxt = act_r;
    if (ctrl.restart) begin
      act_nxt = (IDX == 0);
    end else if (ctrl.step) begin
      act_nxt = (eff & in_use & is_star_r) | left.adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= (IDX == 0);
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && (len == MY_IDX)) begin
      chr_r     <= ctrl.chr;
      is_star_r <= (ctrl.chr == CH_STAR);
      is_ques_r <= (ctrl.chr == CH_QUES);
    end
  end

endmodule

[rtl/wildcard_name_match.sv]
// an end-of-name request shows its result in the cycle after acceptance
// throughput: one request per cycle while in_ready is high, every mask position advances in parallel
// a held result stalls the input only while the result register is still full
// reset (synchronous, rst_n low): mask empty, no overflow, position zero active
// mask storage has no reset and is read only below the loaded length
// ----------------------------------------------------------------------------
// wildcard_name_match
// streaming glob matcher, star and question mark over a row of mask cells
// ----------------------------------------------------------------------------
module wildcard_name_match
  import wnm_pkg::*;
#(
  parameter int MASK_CHARS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  wnm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output wnm_out_t out_data
);

`include "wildcard_name_match_assert.svh"

  localparam int LEN_W = $clog2(MASK_CHARS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MASK_CHARS);

  // stored_len counts cells in use; consecutive stars collapse into one cell,
  // so raw_len tracks the mask as written for the overflow check
  logic [LEN_W-1:0] stored_len_r, stored_len_nxt;
  logic [LEN_W-1:0] raw_len_r, raw_len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_star_r, last_star_nxt;
  logic             act_end_r, act_end_nxt;
  logic             out_valid_r, out_valid_nxt;
  wnm_out_t         out_data_r, out_data_nxt;

  logic             in_acc;
  logic [7:0]       fchr;
  logic             collapse;
  wnm_ctrl_t        ctrl;
  wnm_link_t        links [MASK_CHARS];
  logic [MASK_CHARS:0] eff_vec;
  logic             hit;

  // a request goes in whenever the result register is free or draining
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign fchr     = fold_char(in_data.char_code);
  assign collapse = (fchr == CH_STAR) & last_star_r;

  // ---- row of mask cells, each hands its state to the right neighbor ----
  for (genvar i = 0; i < MASK_CHARS; i++) begin : g_cell
    wnm_link_t left_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_rest
      assign left_in = links[i-1];
    end
    wnm_cell #(
      .LEN_W (LEN_W),
      .IDX   (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .len   (stored_len_r),
      .left  (left_in),
      .right (links[i]),
      .eff   (eff_vec[i])
    );
  end

  // position past the last cell, reached once the whole mask is consumed
  assign eff_vec[MASK_CHARS] = act_end_r |
                               (links[MASK_CHARS-1].star & links[MASK_CHARS-1].act);

  // name matches when the position right after the mask is active
  assign hit = eff_vec[stored_len_r];

  // ---- request decode ----
  always_comb begin
    stored_len_nxt = stored_len_r;
    raw_len_nxt    = raw_len_r;
    ovf_nxt        = ovf_r;
    last_star_nxt  = last_star_r;
    act_end_nxt    = act_end_r;
    out_data_nxt   = out_data_r;
    ctrl           = '0;
    ctrl.chr       = fchr;

    // result leaves when taken
    out_valid_nxt = out_valid_r & ~out_ready;

    if (in_acc) begin
      unique case (in_data.req_type)
        REQ_CLEAR: begin
          stored_len_nxt = '0;
          raw_len_nxt    = '0;
          ovf_nxt        = 1'b0;
          last_star_nxt  = 1'b0;
          ctrl.restart   = 1'b1;
        end
        REQ_APPEND: begin
          if (raw_len_r < LEN_MAX) begin
            raw_len_nxt = raw_len_r + 1'b1;
            // a star right after a star adds nothing to the pattern
            if (!collapse) begin
              ctrl.load      = 1'b1;
              stored_len_nxt = stored_len_r + 1'b1;
              last_star_nxt  = (fchr == CH_STAR);
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          // a mask change drops any partial name
          ctrl.restart = 1'b1;
        end
        REQ_NAME: begin
          ctrl.step   = 1'b1;
          act_end_nxt = links[MASK_CHARS-1].adv;
        end
        REQ_END: begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.matched       = hit & ~ovf_r;
          out_data_nxt.mask_too_long = ovf_r;
          ctrl.restart               = 1'b1;
        end
        default: begin
          ctrl.restart = 1'b1;
        end
      endcase
    end

    if (ctrl.restart) begin
      act_end_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_len_r <= '0;
      raw_len_r    <= '0;
      ovf_r        <= 1'b0;
      last_star_r  <= 1'b0;
      act_end_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      stored_len_r <= stored_len_nxt;
      raw_len_r    <= raw_len_nxt;
      ovf_r        <= ovf_nxt;
      last_star_r  <= last_star_nxt;
      act_end_r    <= act_end_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // ---- checks ----
  // collapsed storage never outgrows the mask as written
  `WNM_ASSERT_IMPL(a_len_order, clk, rst_n, 1'b1, stored_len_r <= raw_len_r)
  // raw length saturates at the store size
  `WNM_ASSERT_IMPL(a_raw_bound, clk, rst_n, 1'b1, raw_len_r <= LEN_MAX)
  // an overflowed mask never reports a match
  `WNM_ASSERT_IMPL(a_ovf_nomatch, clk, rst_n, out_valid_r && out_data_r.mask_too_long,
                   !out_data_r.matched)
  // an accepted end of name always yields a result next cycle
  `WNM_ASSERT_NEXT(a_end_result, clk, rst_n, in_acc && (in_data.req_type == REQ_END),
                   out_valid_r)

endmodule
